FILE: design/ppm_pkg.sv
// Package for the PWM pulse/period meter: codes, widths and constants.
// No dependencies; used by every other design file.
`default_nettype none
package ppm_pkg;

    // Result kind codes (also the phase codes of the measurement cycle)
    localparam logic [1:0] KIND_IGNORED = 2'd0;
    localparam logic [1:0] KIND_PULSE   = 2'd1;
    localparam logic [1:0] KIND_CYCLE   = 2'd2;

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_PULSE = 2'd1;
    localparam logic [1:0] PH_CYCLE = 2'd2;

    // Field widths
    localparam int COUNT_W  = 32;
    localparam int RATE_W   = 32;
    localparam int PERIOD_W = 30;
    localparam int DUTY_W   = 16;

    // Shared divider: 40-bit dividend covers freq*100, 33-bit divisor covers 2*elapsed
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [31:0] CLK_HZ_RESET = 32'd168000000;
    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic [15:0] DUTY_MAX     = 16'hFFFF;

    // Divider control, sequencer to divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage
`default_nettype wire

FILE: design/ppm_cap_if.sv
// Capture event channel: valid/ready handshake with the event payload.
// Depends on ppm_pkg for field widths.
`default_nettype none
interface ppm_cap_if;
    logic                         valid;
    logic                         ready;
    logic [ppm_pkg::COUNT_W-1:0]  capture_count;
    logic                         pin_level;

    modport source (output valid, output capture_count, output pin_level, input ready);
    modport sink   (input valid, input capture_count, input pin_level, output ready);
endinterface
`default_nettype wire

FILE: design/ppm_res_if.sv
// Measurement result channel: valid/ready handshake with the result payload.
// Depends on ppm_pkg for field widths.
`default_nettype none
interface ppm_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic                          zero_interval;
    logic [ppm_pkg::RATE_W-1:0]    pulse_rate;
    logic [ppm_pkg::PERIOD_W-1:0]  pulse_period_ns;
    logic [ppm_pkg::RATE_W-1:0]    frequency_hz;
    logic [ppm_pkg::PERIOD_W-1:0]  cycle_period_ns;
    logic [ppm_pkg::DUTY_W-1:0]    duty_percent;

    modport source (output valid, output result_kind, output zero_interval,
                    output pulse_rate, output pulse_period_ns, output frequency_hz,
                    output cycle_period_ns, output duty_percent, input ready);
    modport sink   (input valid, input result_kind, input zero_interval,
                    input pulse_rate, input pulse_period_ns, input frequency_hz,
                    input cycle_period_ns, input duty_percent, output ready);
endinterface
`default_nettype wire

FILE: design/pwm_pulse_period_meter.sv
// PWM pulse/period meter: top level with the measurement sequencer.
// Depends on ppm_pkg, ppm_cap_if, ppm_res_if and ppm_div.
//
// Usage:
//   i_cap carries timer capture events (capture_count, pin_level); one
//   transaction per edge. o_res returns exactly one result per event: the
//   kind of event, a zero-interval flag and the held measurements.
//   i_cfg_we/i_cfg_wdata write the timer clock in Hz; write it only while
//   the block is idle.
// Cycle cycle:
//   An event with the pin high in the wait phase takes the reference count.
//   The next event measures pulse width (rate and period), the one after
//   measures the full cycle (frequency, period and duty).
// Sequencing:
//   All divisions run through one shared radix-2 divider, 40 steps plus
//   the registered result each. i_cap.ready is high only while the
//   sequencer is idle.
// Reset (synchronous, active low): phase to wait, all held values to zero,
//   clock register to 168 MHz, no result pending.
// Stall: a result waits in the output register while the next event is
//   taken and computed; the sequencer holds its new result until the output
//   register is free, so nothing is dropped.
`default_nettype none
module pwm_pulse_period_meter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ppm_cap_if.sink          i_cap,
    ppm_res_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    localparam int RW = ppm_pkg::RATE_W;
    localparam int PW = ppm_pkg::PERIOD_W;
    localparam int NW = ppm_pkg::DIV_NUM_W;
    localparam int DW = ppm_pkg::DIV_DEN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RATE = 5'b00010,
        S_PER  = 5'b00100,
        S_DUTY = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [31:0]   r_clk_hz;
    logic [1:0]    r_phase, n_phase;
    logic [31:0]   r_first, n_first;
    logic [1:0]    r_kind, n_kind;          // kind of the event in flight
    logic          r_zero, n_zero;
    logic [RW-1:0] r_rate, n_rate;          // rate just computed
    logic [RW-1:0] r_hpr, n_hpr;            // held pulse rate
    logic [PW-1:0] r_hpp, n_hpp;            // held pulse period
    logic [RW-1:0] r_hfr, n_hfr;            // held frequency
    logic [PW-1:0] r_hcp, n_hcp;            // held cycle period
    logic [15:0]   r_hduty, n_hduty;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_kind;
    logic          r_o_zero;
    logic [RW-1:0] r_o_pr, r_o_fr;
    logic [PW-1:0] r_o_pp, r_o_cp;
    logic [15:0]   r_o_duty;
    logic          out_load;

    ppm_pkg::t_div_req div_req;
    logic              div_done;
    logic [NW-1:0]     div_quot;

    logic          cap_acc;
    logic [31:0]   elapsed;
    logic [NW-1:0] freq_x100;

    assign cap_acc = i_cap.valid && i_cap.ready;
    assign elapsed = i_cap.capture_count - r_first;
    // freq * 100 = freq*64 + freq*32 + freq*4
    assign freq_x100 = {2'b0, r_rate, 6'b0} + {3'b0, r_rate, 5'b0} + {6'b0, r_rate, 2'b0};

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_first     = r_first;
        n_kind      = r_kind;
        n_zero      = r_zero;
        n_rate      = r_rate;
        n_hpr       = r_hpr;
        n_hpp       = r_hpp;
        n_hfr       = r_hfr;
        n_hcp       = r_hcp;
        n_hduty     = r_hduty;
        div_req     = '0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;

        case (r_state)
            S_IDLE: begin
                if (cap_acc) begin
                    n_zero  = 1'b0;
                    n_state = S_DONE;
                    case (r_phase)
                        ppm_pkg::PH_PULSE, ppm_pkg::PH_CYCLE: begin
                            n_kind  = r_phase;
                            n_phase = (r_phase == ppm_pkg::PH_PULSE) ? ppm_pkg::PH_CYCLE
                                                                     : ppm_pkg::PH_WAIT;
                            if (elapsed == '0) begin
                                n_zero = 1'b1;
                            end else begin
                                // rate = clk / (2*elapsed) + 1
                                div_req.start = 1'b1;
                                div_req.num   = NW'(r_clk_hz);
                                div_req.den   = {elapsed, 1'b0};
                                n_state       = S_RATE;
                            end
                        end
                        default: begin
                            // wait phase (unused code 3 behaves the same)
                            n_kind  = ppm_pkg::KIND_IGNORED;
                            n_phase = ppm_pkg::PH_WAIT;
                            if (i_cap.pin_level) begin
                                n_first = i_cap.capture_count;
                                n_phase = ppm_pkg::PH_PULSE;
                            end
                        end
                    endcase
                end
            end
            S_RATE: begin
                if (div_done) begin
                    n_rate        = RW'(div_quot) + 1'b1;
                    div_req.start = 1'b1;
                    div_req.num   = NW'(ppm_pkg::NS_PER_S);
                    div_req.den   = DW'(n_rate);
                    n_state       = S_PER;
                end
            end
            S_PER: begin
                if (div_done) begin
                    if (r_kind == ppm_pkg::KIND_PULSE) begin
                        n_hpr   = r_rate;
                        n_hpp   = PW'(div_quot);
                        n_state = S_DONE;
                    end else begin
                        n_hfr = r_rate;
                        n_hcp = PW'(div_quot);
                        if (r_hpr == '0) begin
                            n_hduty = ppm_pkg::DUTY_MAX;
                            n_state = S_DONE;
                        end else begin
                            div_req.start = 1'b1;
                            div_req.num   = freq_x100;
                            div_req.den   = DW'(r_hpr);
                            n_state       = S_DUTY;
                        end
                    end
                end
            end
            S_DUTY: begin
                if (div_done) begin
                    // saturate the duty quotient at 16 bits
                    n_hduty = (div_quot[NW-1:16] != '0) ? ppm_pkg::DUTY_MAX : div_quot[15:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clk_hz    <= ppm_pkg::CLK_HZ_RESET;
            r_phase     <= ppm_pkg::PH_WAIT;
            r_first     <= '0;
            r_hpr       <= '0;
            r_hpp       <= '0;
            r_hfr       <= '0;
            r_hcp       <= '0;
            r_hduty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_hpr       <= n_hpr;
            r_hpp       <= n_hpp;
            r_hfr       <= n_hfr;
            r_hcp       <= n_hcp;
            r_hduty     <= n_hduty;
            r_out_valid <= n_out_valid;
        end
        r_kind <= n_kind;
        r_zero <= n_zero;
        r_rate <= n_rate;
        if (out_load) begin
            r_o_kind <= r_kind;
            r_o_zero <= r_zero;
            r_o_pr   <= r_hpr;
            r_o_pp   <= r_hpp;
            r_o_fr   <= r_hfr;
            r_o_cp   <= r_hcp;
            r_o_duty <= r_hduty;
        end
    end

    ppm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign i_cap.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_o_kind;
    assign o_res.zero_interval   = r_o_zero;
    assign o_res.pulse_rate      = r_o_pr;
    assign o_res.pulse_period_ns = r_o_pp;
    assign o_res.frequency_hz    = r_o_fr;
    assign o_res.cycle_period_ns = r_o_cp;
    assign o_res.duty_percent    = r_o_duty;

    // Divider is only launched from idle or on a previous division's completion
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == S_IDLE && cap_acc) || div_done)
        else $error("divider started out of sequence");

    // A finished result is never overwritten while the receiver stalls
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_res.ready) |=> r_state == S_DONE)
        else $error("result dropped under stall");

    // Phase never takes the unused code
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("phase reached unused code");

    // Zero interval only reported for measuring events
    a_zero_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_interval) |->
            (o_res.result_kind == ppm_pkg::KIND_PULSE ||
             o_res.result_kind == ppm_pkg::KIND_CYCLE))
        else $error("zero interval on an ignored event");

endmodule
`default_nettype wire

FILE: design/ppm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ppm_pkg (widths, t_div_req).
`default_nettype none
module ppm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ppm_pkg::t_div_req             i_req,
    output logic                               o_done,
    output logic [ppm_pkg::DIV_NUM_W-1:0]      o_quot
);
    localparam int NW = ppm_pkg::DIV_NUM_W;
    localparam int DW = ppm_pkg::DIV_DEN_W;
    localparam int CW = ppm_pkg::DIV_CNT_W;

    logic [DW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_quo[NW-1]};
        diff   = trial - {1'b0, r_den};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[DW]) begin
                n_rem = diff[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for pwm_pulse_period_meter: capture-event stimulus, scoreboard and result checks.
// Depends on ppm_pkg, the ppm_cap_if and ppm_res_if interfaces and the meter RTL.
`default_nettype none
module tb_top;

    // Run limits. The limit leaves ample room for the slowest event, the
    // random idle gaps on each side and the long receiver hold-offs.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_EVERY    = 160;    // results between long hold-offs
    localparam int HOLD_CYCLES   = 1200;   // length of one hold-off
    localparam int DRAIN_CYCLES  = 200;    // settle time after the last result
    localparam logic [63:0] DUTY_SCALE = 64'd100;

    typedef struct {
        logic [ppm_pkg::COUNT_W-1:0] count;
        logic                        level;
    } t_cap_event;

    typedef struct {
        logic [1:0]                   kind;
        logic                         zero;
        logic [ppm_pkg::RATE_W-1:0]   pulse_rate;
        logic [ppm_pkg::PERIOD_W-1:0] pulse_ns;
        logic [ppm_pkg::RATE_W-1:0]   freq;
        logic [ppm_pkg::PERIOD_W-1:0] cycle_ns;
        logic [ppm_pkg::DUTY_W-1:0]   duty;
    } t_meas;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    ppm_cap_if cap_if ();
    ppm_res_if res_if ();

    pwm_pulse_period_meter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cap       (cap_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Events waiting to be offered, and predicted results waiting to arrive
    t_cap_event event_queue[$];
    t_meas      expected_results[$];

    // Meter model state, mirrored from the block's behavior
    logic [31:0]                  clock_hz;
    logic [1:0]                   meter_phase;
    logic [ppm_pkg::COUNT_W-1:0]  ref_count;
    logic [ppm_pkg::RATE_W-1:0]   held_rate;
    logic [ppm_pkg::PERIOD_W-1:0] held_pulse_ns;
    logic [ppm_pkg::RATE_W-1:0]   held_freq;
    logic [ppm_pkg::PERIOD_W-1:0] held_cycle_ns;
    logic [ppm_pkg::DUTY_W-1:0]   held_duty;

    int    errors;
    int    results_got;
    int    hold_left;
    int    last_hold_mark;
    int    send_wait;
    int    recv_wait;
    bit    send_idle_on;
    bit    recv_idle_on;
    int    cycle_count;
    t_meas want;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // clock / (2*elapsed) + 1; the doubled divisor is kept at 33 bits so it
    // never wraps, and a zero clock just gives 1.
    function automatic logic [31:0] rate_for(input logic [31:0] elapsed);
        logic [63:0] q;
        q = {32'd0, clock_hz} / {31'd0, elapsed, 1'b0} + 64'd1;
        return q[31:0];
    endfunction

    function automatic logic [ppm_pkg::PERIOD_W-1:0] period_for(input logic [31:0] rate);
        logic [31:0] q;
        q = {2'b00, ppm_pkg::NS_PER_S} / rate;
        return q[ppm_pkg::PERIOD_W-1:0];
    endfunction

    // Advance the meter model by one capture event and return its result.
    function automatic t_meas measure_event(input logic [31:0] count, input logic level);
        t_meas       r;
        logic [31:0] elapsed;
        logic [63:0] q;
        r.kind = ppm_pkg::KIND_IGNORED;
        r.zero = 1'b0;
        case (meter_phase)
            ppm_pkg::PH_PULSE, ppm_pkg::PH_CYCLE: begin
                // modulo-2^32 difference, so a timer wrap is handled exactly
                elapsed = count - ref_count;
                r.kind  = meter_phase;
                if (elapsed == 32'd0) begin
                    // zero interval: flag it, keep every held value
                    r.zero = 1'b1;
                end else if (meter_phase == ppm_pkg::PH_PULSE) begin
                    held_rate     = rate_for(elapsed);
                    held_pulse_ns = period_for(held_rate);
                end else begin
                    held_freq     = rate_for(elapsed);
                    held_cycle_ns = period_for(held_freq);
                    if (held_rate == '0) begin
                        held_duty = ppm_pkg::DUTY_MAX;
                    end else begin
                        q = ({32'd0, held_freq} * DUTY_SCALE) / {32'd0, held_rate};
                        held_duty = (q > {48'd0, ppm_pkg::DUTY_MAX}) ?
                                    ppm_pkg::DUTY_MAX : q[ppm_pkg::DUTY_W-1:0];
                    end
                end
                meter_phase = (meter_phase == ppm_pkg::PH_PULSE) ? ppm_pkg::PH_CYCLE
                                                                 : ppm_pkg::PH_WAIT;
            end
            default: begin
                // wait phase (and the unreachable fourth code): pin high
                // takes the reference, pin low is ignored
                meter_phase = ppm_pkg::PH_WAIT;
                if (level) begin
                    ref_count   = count;
                    meter_phase = ppm_pkg::PH_PULSE;
                end
            end
        endcase
        r.pulse_rate = held_rate;
        r.pulse_ns   = held_pulse_ns;
        r.freq       = held_freq;
        r.cycle_ns   = held_cycle_ns;
        r.duty       = held_duty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued events, predicts each one at its transaction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            cap_if.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (cap_if.valid && cap_if.ready) begin
                expected_results.push_back(
                    measure_event(cap_if.capture_count, cap_if.pin_level));
                void'(event_queue.pop_front());
                // switch between idling and back-to-back now and then
                if ($urandom_range(0, 31) == 0) send_idle_on = !send_idle_on;
                send_wait = send_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (cap_if.valid && !cap_if.ready) begin
                // offered but not taken: hold the payload
            end else if (send_wait != 0) begin
                send_wait--;
                cap_if.valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
                cap_if.valid         <= 1'b1;
                cap_if.capture_count <= event_queue[0].count;
                cap_if.pin_level     <= event_queue[0].level;
            end else begin
                cap_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results and compares them with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            results_got  <= 0;
            recv_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no event pending");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 32'(want.kind),
                                32'(res_if.result_kind));
                    check_field("zero_interval", 32'(want.zero),
                                32'(res_if.zero_interval));
                    check_field("pulse_rate", want.pulse_rate, res_if.pulse_rate);
                    check_field("pulse_period_ns", 32'(want.pulse_ns),
                                32'(res_if.pulse_period_ns));
                    check_field("frequency_hz", want.freq, res_if.frequency_hz);
                    check_field("cycle_period_ns", 32'(want.cycle_ns),
                                32'(res_if.cycle_period_ns));
                    check_field("duty_percent", 32'(want.duty),
                                32'(res_if.duty_percent));
                end
                results_got <= results_got + 1;
                if ($urandom_range(0, 31) == 0) recv_idle_on = !recv_idle_on;
                recv_wait = recv_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (recv_wait != 0) begin
                recv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= (hold_left == 0);
            end
        end
    end

    // Long receiver hold-off every HOLD_EVERY results. The driver keeps
    // offering meanwhile, so the output register and the sequencer fill
    // and the capture channel has to stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left      <= 0;
            last_hold_mark <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_got != 0 && results_got % HOLD_EVERY == 0 &&
                     results_got != last_hold_mark) begin
            hold_left      <= HOLD_CYCLES;
            last_hold_mark <= results_got;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_event(input logic [31:0] count, input logic level);
        t_cap_event ev;
        ev.count = count;
        ev.level = level;
        event_queue.push_back(ev);
    endtask

    // Timer interval between edges: mostly short, some long, a few zero
    // and a few close to the full 32-bit span.
    function automatic logic [31:0] rand_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2, 3: return $urandom_range(1, 1000);
            4:       return $urandom_range(1, 16);
            5, 6:    return $urandom_range(1, 1 << 20);
            7:       return $urandom;
            8:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom_range(1, 1 << 12);
        endcase
    endfunction

    // Mostly complete reference/pulse/cycle sequences with random timing,
    // plus pin-low noise, lone references and fully random events that
    // knock the sequence out of step.
    task automatic add_random(input int n);
        int          made;
        int          pick;
        logic [31:0] base;
        logic [31:0] pulse_at;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                base     = $urandom;
                pulse_at = base + rand_interval();
                push_event(base, 1'b1);
                push_event(pulse_at, 1'($urandom_range(0, 1)));
                push_event(pulse_at + rand_interval(), 1'($urandom_range(0, 1)));
                made += 3;
            end else if (pick == 7) begin
                // ignored while waiting, does not count
                push_event($urandom, 1'b0);
            end else if (pick == 8) begin
                push_event($urandom, 1'b1);
                made++;
            end else begin
                push_event($urandom, 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    // Block until every queued event went in and every result came back.
    task automatic wait_drained();
        while (event_queue.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write, only issued with the block idle
    task automatic write_clock(input logic [31:0] hz);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(posedge clk);
        cfg_we    <= 1'b0;
        clock_hz = hz;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        cap_if.valid         = 1'b0;
        cap_if.capture_count = '0;
        cap_if.pin_level     = 1'b0;
        res_if.ready         = 1'b0;
        errors               = 0;
        cycle_count          = 0;
        send_idle_on         = 1'b1;
        recv_idle_on         = 1'b1;

        clock_hz      = ppm_pkg::CLK_HZ_RESET;
        meter_phase   = ppm_pkg::PH_WAIT;
        ref_count     = '0;
        held_rate     = '0;
        held_pulse_ns = '0;
        held_freq     = '0;
        held_cycle_ns = '0;
        held_duty     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset clock value
        push_event(32'h0000_0000, 1'b0);   // pin low while waiting: ignored
        // pulse with zero interval right after reset, so the cycle sees
        // a zero held pulse rate and duty saturates
        push_event(32'd100, 1'b1);
        push_event(32'd100, 1'b0);
        push_event(32'd300, 1'b1);
        // counts straddling the timer wrap
        push_event(32'hFFFF_FFF0, 1'b1);
        push_event(32'h0000_0010, 1'b1);
        push_event(32'h0000_0100, 1'b0);
        // full-span pulse (33-bit divisor, rate 1), then a one-tick cycle:
        // freq*100 far exceeds the duty range
        push_event(32'h0000_0000, 1'b1);
        push_event(32'hFFFF_FFFF, 1'b0);
        push_event(32'h0000_0001, 1'b1);
        // zero interval on the cycle measurement
        push_event(32'd7, 1'b1);
        push_event(32'd17, 1'b1);
        push_event(32'd7, 1'b0);
        push_event(32'h7FFF_FFFF, 1'b0);   // ignored again
        add_random(160);
        wait_drained();

        // Largest clock: one-tick pulse gives the largest rate, period 0
        write_clock(32'hFFFF_FFFF);
        push_event(32'd5, 1'b1);
        push_event(32'd6, 1'b0);
        push_event(32'd8, 1'b1);
        add_random(120);
        wait_drained();

        // Zero clock: rate and frequency collapse to 1
        write_clock(32'd0);
        push_event(32'd1, 1'b1);
        push_event(32'd2, 1'b0);
        push_event(32'd3, 1'b1);
        add_random(30);
        wait_drained();

        // Smallest legal clock
        write_clock(32'd1);
        add_random(90);
        wait_drained();

        // Random clock values
        write_clock($urandom);
        add_random(50);
        wait_drained();
        write_clock($urandom_range(1, 1 << 16));
        add_random(50);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
